// ----- design/ppw_pkg.sv -----
package ppw_pkg;

    localparam int CW = 32;
    localparam int XW = 10;
    localparam int PW = 24;
    localparam int QW = 10;
    localparam int MW = CW + XW + 1;
    localparam int NW = MW + 2;
    localparam int RW = NW + 15;
    localparam int CIW = 3;
    localparam int FRONT_STAGES = 3;
    localparam int DEFAULT_WIDTH = 1024;
    localparam int DEFAULT_HEIGHT = 1024;

    localparam logic [CIW-1:0] REG_XX = 3'd0;
    localparam logic [CIW-1:0] REG_XY = 3'd1;
    localparam logic [CIW-1:0] REG_XC = 3'd2;
    localparam logic [CIW-1:0] REG_YX = 3'd3;
    localparam logic [CIW-1:0] REG_YY = 3'd4;
    localparam logic [CIW-1:0] REG_YC = 3'd5;
    localparam logic [CIW-1:0] REG_WX = 3'd6;
    localparam logic [CIW-1:0] REG_WY = 3'd7;

    localparam logic [CW-1:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [NW-1:0] den;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
        logic          keep;
        logic [PW-1:0] pixel;
    } t_div;

endpackage

// ----- design/projective_pixel_warp.sv -----
// Channel   Direction  Handshake                    Payload
// source    in         i_src_valid / o_src_ready    i_src_x, i_src_y, i_src_pixel
// dest      out        o_dst_valid / i_dst_ready    o_dst_x, o_dst_y, o_dst_pixel
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// One pixel is taken per cycle unless a destination stall backs up to the input; a result
// is presented only for a pixel that maps inside the image. The pipeline holds three arithmetic
// stages, one stage per quotient bit of the restoring divider, and the output register.
// Synchronous active-low reset empties every stage and restores the identity matrix.
// Each stage holds its item while the stage after it is full and stalled, so bubbles close.
module projective_pixel_warp #(
    parameter int IMAGE_WIDTH  = ppw_pkg::DEFAULT_WIDTH,
    parameter int IMAGE_HEIGHT = ppw_pkg::DEFAULT_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ppw_pkg::CIW-1:0]   i_cfg_index,
    input  logic [ppw_pkg::CW-1:0]    i_cfg_data,
    input  logic                      i_src_valid,
    output logic                      o_src_ready,
    input  logic [ppw_pkg::XW-1:0]    i_src_x,
    input  logic [ppw_pkg::XW-1:0]    i_src_y,
    input  logic [ppw_pkg::PW-1:0]    i_src_pixel,
    output logic                      o_dst_valid,
    input  logic                      i_dst_ready,
    output logic [ppw_pkg::QW-1:0]    o_dst_x,
    output logic [ppw_pkg::QW-1:0]    o_dst_y,
    output logic [ppw_pkg::PW-1:0]    o_dst_pixel
);

    localparam int NS = ppw_pkg::FRONT_STAGES + ppw_pkg::QW + 1;
    localparam logic [ppw_pkg::QW-1:0] LIM_X = ppw_pkg::QW'(IMAGE_WIDTH - 1);
    localparam logic [ppw_pkg::QW-1:0] LIM_Y = ppw_pkg::QW'(IMAGE_HEIGHT - 1);

    logic signed [ppw_pkg::CW-1:0] r_xx, r_xy, r_xc, r_yx, r_yy, r_yc, r_wx, r_wy;
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    logic signed [ppw_pkg::MW-1:0] r_pxx, r_pxy, r_pyx, r_pyy, r_pwx, r_pwy;
    logic [ppw_pkg::PW-1:0]        r_pix0, r_pix1;
    logic signed [ppw_pkg::NW-1:0] r_nx, r_ny, r_d;
    logic signed [ppw_pkg::NW-1:0] n_nx, n_ny, n_d;
    logic signed [ppw_pkg::XW:0]   sx, sy;

    ppw_pkg::t_div r_div [ppw_pkg::QW+1];
    ppw_pkg::t_div n_div [ppw_pkg::QW+1];
    ppw_pkg::t_div last;
    logic          n_out_valid;
    logic          r_out_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx <= ppw_pkg::ONE_Q16;
            r_xy <= '0;
            r_xc <= '0;
            r_yx <= '0;
            r_yy <= ppw_pkg::ONE_Q16;
            r_yc <= '0;
            r_wx <= '0;
            r_wy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppw_pkg::REG_XX: r_xx <= i_cfg_data;
                ppw_pkg::REG_XY: r_xy <= i_cfg_data;
                ppw_pkg::REG_XC: r_xc <= i_cfg_data;
                ppw_pkg::REG_YX: r_yx <= i_cfg_data;
                ppw_pkg::REG_YY: r_yy <= i_cfg_data;
                ppw_pkg::REG_YC: r_yc <= i_cfg_data;
                ppw_pkg::REG_WX: r_wx <= i_cfg_data;
                ppw_pkg::REG_WY: r_wy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_dst_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_src_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_src_valid;
            end
            for (int k = 1; k < NS - 1; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en[NS-1]) begin
                r_v[NS-1] <= r_v[NS-2] && n_out_valid;
            end
        end
    end

    assign sx = {1'b0, i_src_x};
    assign sy = {1'b0, i_src_y};

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pxx  <= r_xx * sx;
            r_pxy  <= r_xy * sy;
            r_pyx  <= r_yx * sx;
            r_pyy  <= r_yy * sy;
            r_pwx  <= r_wx * sx;
            r_pwy  <= r_wy * sy;
            r_pix0 <= i_src_pixel;
        end
    end

    always_comb begin
        n_nx = ppw_pkg::NW'(r_pxx) + ppw_pkg::NW'(r_pxy) + ppw_pkg::NW'(r_xc);
        n_ny = ppw_pkg::NW'(r_pyx) + ppw_pkg::NW'(r_pyy) + ppw_pkg::NW'(r_yc);
        n_d  = ppw_pkg::NW'(r_pwx) + ppw_pkg::NW'(r_pwy) + (ppw_pkg::NW'(1) <<< 30);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_nx   <= n_nx;
            r_ny   <= n_ny;
            r_d    <= n_d;
            r_pix1 <= r_pix0;
        end
    end

    ppw_norm u_norm (
        .i_nx    (r_nx),
        .i_ny    (r_ny),
        .i_d     (r_d),
        .i_pixel (r_pix1),
        .o_div   (n_div[0])
    );

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_div[0] <= n_div[0];
        end
    end

    for (genvar k = 0; k < ppw_pkg::QW; k++) begin : g_div
        ppw_div_step #(.BIT(ppw_pkg::QW - 1 - k)) u_step (
            .i_div (r_div[k]),
            .o_div (n_div[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (en[ppw_pkg::FRONT_STAGES + k]) begin
                r_div[k+1] <= n_div[k+1];
            end
        end
    end

    assign last = r_div[ppw_pkg::QW];
    assign n_out_valid = last.keep
        && ((last.q_x < LIM_X) || ((last.q_x == LIM_X) && (last.rem_x == '0)))
        && ((last.q_y < LIM_Y) || ((last.q_y == LIM_Y) && (last.rem_y == '0)));

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            o_dst_x     <= last.q_x;
            o_dst_y     <= last.q_y;
            o_dst_pixel <= last.pixel;
            r_out_keep  <= n_out_valid;
        end
    end

    assign o_dst_valid = r_v[NS-1];

    a_x_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst_valid |-> (o_dst_x <= LIM_X) && (o_dst_y <= LIM_Y))
        else $error("destination outside the image");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst_valid |-> r_out_keep)
        else $error("dropped pixel presented");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_dst_valid |-> o_src_ready)
        else $error("input stalled with an empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_dst_valid)
        else $error("result present after reset");

endmodule

// ----- design/ppw_norm.sv -----
module ppw_norm (
    input  logic signed [ppw_pkg::NW-1:0] i_nx,
    input  logic signed [ppw_pkg::NW-1:0] i_ny,
    input  logic signed [ppw_pkg::NW-1:0] i_d,
    input  logic        [ppw_pkg::PW-1:0] i_pixel,
    output ppw_pkg::t_div                 o_div
);

    logic                          d_neg;
    logic signed [ppw_pkg::NW:0]   d_abs;
    logic signed [ppw_pkg::NW:0]   nx_s;
    logic signed [ppw_pkg::NW:0]   ny_s;
    logic signed [ppw_pkg::RW-1:0] num_x;
    logic signed [ppw_pkg::RW-1:0] num_y;
    logic        [ppw_pkg::RW-1:0] bound;

    always_comb begin
        d_neg = i_d[ppw_pkg::NW-1];
        d_abs = d_neg ? -(ppw_pkg::NW+1)'(i_d) : (ppw_pkg::NW+1)'(i_d);
        nx_s  = d_neg ? -(ppw_pkg::NW+1)'(i_nx) : (ppw_pkg::NW+1)'(i_nx);
        ny_s  = d_neg ? -(ppw_pkg::NW+1)'(i_ny) : (ppw_pkg::NW+1)'(i_ny);
        num_x = ppw_pkg::RW'(nx_s) <<< 14;
        num_y = ppw_pkg::RW'(ny_s) <<< 14;
        bound = ppw_pkg::RW'(d_abs) << ppw_pkg::QW;

        o_div.rem_x = num_x;
        o_div.rem_y = num_y;
        o_div.den   = d_abs[ppw_pkg::NW-1:0];
        o_div.q_x   = '0;
        o_div.q_y   = '0;
        o_div.pixel = i_pixel;
        o_div.keep  = (i_d != '0) && !num_x[ppw_pkg::RW-1] && !num_y[ppw_pkg::RW-1]
                      && (num_x < bound) && (num_y < bound);
    end

endmodule

// ----- design/ppw_div_step.sv -----
module ppw_div_step #(
    parameter int BIT = 0
) (
    input  ppw_pkg::t_div i_div,
    output ppw_pkg::t_div o_div
);

    logic [ppw_pkg::RW-1:0] trial;

    always_comb begin
        trial = ppw_pkg::RW'(i_div.den) << BIT;
        o_div = i_div;
        if (i_div.rem_x >= trial) begin
            o_div.rem_x    = i_div.rem_x - trial;
            o_div.q_x[BIT] = 1'b1;
        end
        if (i_div.rem_y >= trial) begin
            o_div.rem_y    = i_div.rem_y - trial;
            o_div.q_y[BIT] = 1'b1;
        end
    end

endmodule
